// ===== hdl/als_pkg.sv =====
// Shared types and constants for the adaptive lane signal arbiter.
// Used by the channel interfaces, the lane core, the merge stage and the top level.
package als_pkg;

  localparam int LANES     = 4;
  localparam int CNT_W     = 8;
  localparam int WAIT_W    = 10;
  localparam int GREEN_W   = 8;
  localparam int SCORE_W   = 11;
  localparam int LANE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int INC_W     = 4;

  localparam logic [WAIT_W-1:0]  WAIT_MAX  = 10'd1023;
  localparam logic [GREEN_W-1:0] GREEN_MAX = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_GREEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VEH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_INC  = 2'd2;

  localparam logic [LANES-1:0] LIGHTS_RST = 4'b0100;

  typedef struct packed {
    logic [GREEN_W-1:0] max_green;
    logic [CNT_W-1:0]   min_veh;
    logic [INC_W-1:0]   wait_inc;
  } cfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   count;
    logic               hit;
  } lane_res_t;

endpackage

// ===== hdl/als_ifs.sv =====
// Valid/ready channel interfaces for the lane count input and the light result.
// Depends on als_pkg for field widths.
interface als_in_if;
  logic                     valid;
  logic                     ready;
  logic [als_pkg::CNT_W-1:0] count_lane0;
  logic [als_pkg::CNT_W-1:0] count_lane1;
  logic [als_pkg::CNT_W-1:0] count_lane2;
  logic [als_pkg::CNT_W-1:0] count_lane3;
  modport source (output valid, count_lane0, count_lane1, count_lane2, count_lane3,
                  input ready);
  modport sink   (input valid, count_lane0, count_lane1, count_lane2, count_lane3,
                  output ready);
endinterface

interface als_out_if;
  logic                       valid;
  logic                       ready;
  logic [als_pkg::LANES-1:0]  light_mask;
  logic [als_pkg::LANE_W-1:0] chosen_lane;
  logic                       forced;
  modport source (output valid, light_mask, chosen_lane, forced, input ready);
  modport sink   (input valid, light_mask, chosen_lane, forced, output ready);
endinterface

// ===== hdl/als_lane.sv =====
// One lane: green/wait timers, saturating update and priority score.
// Depends on als_pkg.
module als_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          lit,
  input  logic [als_pkg::CNT_W-1:0]     count,
  input  als_pkg::cfg_t                 cfg,
  output als_pkg::lane_res_t            res
);
  import als_pkg::*;

  logic [WAIT_W-1:0]  wait_r,  wait_nxt;
  logic [GREEN_W-1:0] green_r, green_nxt;
  logic [WAIT_W:0]    wsum;

  always_comb begin
    wsum = {1'b0, wait_r} + {{(WAIT_W+1-INC_W){1'b0}}, cfg.wait_inc};
    if (lit) begin
      wait_nxt  = '0;
      green_nxt = (green_r == GREEN_MAX) ? green_r : green_r + 1'b1;
    end else begin
      wait_nxt  = (wsum > {1'b0, WAIT_MAX}) ? WAIT_MAX : wsum[WAIT_W-1:0];
      green_nxt = '0;
    end
    res.score = {{(SCORE_W-CNT_W-1){1'b0}}, count, 1'b0}
              + {{(SCORE_W-WAIT_W){1'b0}}, wait_nxt};
    res.count = count;
    res.hit   = lit && (green_nxt >= cfg.max_green);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r  <= '0;
      green_r <= '0;
    end else if (upd) begin
      wait_r  <= wait_nxt;
      green_r <= green_nxt;
    end
  end

endmodule

// ===== hdl/als_merge.sv =====
// Merge stage: picks the highest-scoring lane and decides the next light mask.
// Depends on als_pkg.
module als_merge (
  input  als_pkg::lane_res_t           res [als_pkg::LANES],
  input  logic [als_pkg::LANES-1:0]    lights,
  input  als_pkg::cfg_t                cfg,
  output logic [als_pkg::LANES-1:0]    mask_nxt,
  output logic [als_pkg::LANE_W-1:0]   chosen,
  output logic                         forced
);
  import als_pkg::*;

  logic [SCORE_W-1:0] best_score;
  logic [LANES-1:0]   bit_sel;
  logic               grant;

  always_comb begin
    chosen     = '0;
    best_score = res[0].score;
    forced     = res[0].hit;
    for (int i = 1; i < LANES; i++) begin
      forced = forced | res[i].hit;
      if (res[i].score > best_score) begin
        best_score = res[i].score;
        chosen     = LANE_W'(i);
      end
    end
    bit_sel  = LANES'(1) << chosen;
    grant    = forced || (res[chosen].count > cfg.min_veh);
    mask_nxt = grant ? bit_sel : (lights & bit_sel);
  end

endmodule

// ===== hdl/adaptive_lane_signal_arbiter.sv =====
// Adaptive lane signal arbiter, top level.
// Input channel in_if carries one tick: the vehicle count of each of four lanes.
// Output channel out_if returns one transaction per tick: the new light mask,
// the lane with the highest score and a flag set when the green limit forced it.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 green limit,
// 1 grant threshold, 2 wait increment); an unused index is ignored.
// Latency: the result is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while the receiver takes results; four lane
// cores score in parallel and a combinational merge picks the winner, with
// lane timers and the light mask updated at acceptance.
// Reset (synchronous, rst_n low): lane 2 green, all timers zero, registers at
// 8 / 5 / 2, output empty.
// When the receiver stalls the result holds in the output register and
// in_if.ready drops until it is taken.
module adaptive_lane_signal_arbiter (
  input  logic                              clk,
  input  logic                              rst_n,
  als_in_if.sink                            in_if,
  als_out_if.source                         out_if,
  input  logic                              cfg_we,
  input  logic [als_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [als_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import als_pkg::*;

  cfg_t               cfg_r;
  logic [LANES-1:0]   lights_r;
  logic               out_valid_r;
  logic [LANES-1:0]   out_mask_r;
  logic [LANE_W-1:0]  out_lane_r;
  logic               out_forced_r;

  logic               accept;
  logic [CNT_W-1:0]   counts [LANES];
  lane_res_t          res    [LANES];
  logic [LANES-1:0]   mask_nxt;
  logic [LANE_W-1:0]  chosen;
  logic               forced;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  assign counts[0] = in_if.count_lane0;
  assign counts[1] = in_if.count_lane1;
  assign counts[2] = in_if.count_lane2;
  assign counts[3] = in_if.count_lane3;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    als_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .upd   (accept),
      .lit   (lights_r[g]),
      .count (counts[g]),
      .cfg   (cfg_r),
      .res   (res[g])
    );
  end

  als_merge u_merge (
    .res      (res),
    .lights   (lights_r),
    .cfg      (cfg_r),
    .mask_nxt (mask_nxt),
    .chosen   (chosen),
    .forced   (forced)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_green <= 8'd8;
      cfg_r.min_veh   <= 8'd5;
      cfg_r.wait_inc  <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAX_GREEN: cfg_r.max_green <= cfg_wdata;
        REG_MIN_VEH:   cfg_r.min_veh   <= cfg_wdata;
        REG_WAIT_INC:  cfg_r.wait_inc  <= cfg_wdata[INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_r    <= LIGHTS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        lights_r    <= mask_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_mask_r   <= mask_nxt;
      out_lane_r   <= chosen;
      out_forced_r <= forced;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.light_mask  = out_mask_r;
  assign out_if.chosen_lane = out_lane_r;
  assign out_if.forced      = out_forced_r;

  a_lights_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(lights_r)) else $error("more than one lane green");

  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_if.valid) else $error("accepted tick gave no result");

  a_forced_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.forced) |-> out_if.light_mask[out_if.chosen_lane])
    else $error("forced switch did not turn winner green");

  a_mask_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.light_mask == lights_r))
    else $error("result mask differs from light state");

endmodule
